@@ hw/rtl/modexp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, reset constants and the sequencer program of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned FieldW       = 31;
  localparam int unsigned ExpBits      = 31;
  localparam int unsigned ExpCntW      = $clog2(ExpBits);
  localparam int unsigned MulCntW      = $clog2(FieldW);
  localparam int unsigned UpcW         = 4;
  localparam logic [FieldW-1:0] ModulusReset = FieldW'(998244353);

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_LD_BASE  = 4'd2,
    OP_MUL      = 4'd3,
    OP_WB_BASE  = 4'd4,
    OP_LD_SQ    = 4'd5,
    OP_WB_ACC   = 4'd6,
    OP_LD_MB    = 4'd7,
    OP_NEXT_BIT = 4'd8,
    OP_EMIT     = 4'd9
  } op_e;

  // jump conditions: taken -> target, else fall through
  typedef enum logic [2:0] {
    CD_NEVER    = 3'd0,
    CD_ALWAYS   = 3'd1,
    CD_NO_INPUT = 3'd2,
    CD_MUL_BUSY = 3'd3,
    CD_BIT_ZERO = 3'd4,
    CD_BIT_MORE = 3'd5,
    CD_OUT_BUSY = 3'd6
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [UpcW-1:0] target;
  } ucode_t;

  // program addresses
  localparam logic [UpcW-1:0] StIdle    = 4'd0;
  localparam logic [UpcW-1:0] StLdBase  = 4'd1;
  localparam logic [UpcW-1:0] StMulBase = 4'd2;
  localparam logic [UpcW-1:0] StWbBase  = 4'd3;
  localparam logic [UpcW-1:0] StLdSq    = 4'd4;
  localparam logic [UpcW-1:0] StMulSq   = 4'd5;
  localparam logic [UpcW-1:0] StWbSq    = 4'd6;
  localparam logic [UpcW-1:0] StLdMb    = 4'd7;
  localparam logic [UpcW-1:0] StMulMb   = 4'd8;
  localparam logic [UpcW-1:0] StWbMb    = 4'd9;
  localparam logic [UpcW-1:0] StNextBit = 4'd10;
  localparam logic [UpcW-1:0] StOutWait = 4'd11;
  localparam logic [UpcW-1:0] StEmit    = 4'd12;

  function automatic ucode_t ucode_rom(input logic [UpcW-1:0] upc);
    ucode_t w;
    w = '{op: OP_NOP, cond: CD_ALWAYS, target: StIdle};
    unique case (upc)
      StIdle:    w = '{op: OP_ACCEPT,   cond: CD_NO_INPUT, target: StIdle};
      StLdBase:  w = '{op: OP_LD_BASE,  cond: CD_NEVER,    target: StIdle};
      StMulBase: w = '{op: OP_MUL,      cond: CD_MUL_BUSY, target: StMulBase};
      StWbBase:  w = '{op: OP_WB_BASE,  cond: CD_NEVER,    target: StIdle};
      StLdSq:    w = '{op: OP_LD_SQ,    cond: CD_NEVER,    target: StIdle};
      StMulSq:   w = '{op: OP_MUL,      cond: CD_MUL_BUSY, target: StMulSq};
      StWbSq:    w = '{op: OP_WB_ACC,   cond: CD_BIT_ZERO, target: StNextBit};
      StLdMb:    w = '{op: OP_LD_MB,    cond: CD_NEVER,    target: StIdle};
      StMulMb:   w = '{op: OP_MUL,      cond: CD_MUL_BUSY, target: StMulMb};
      StWbMb:    w = '{op: OP_WB_ACC,   cond: CD_NEVER,    target: StIdle};
      StNextBit: w = '{op: OP_NEXT_BIT, cond: CD_BIT_MORE, target: StLdSq};
      StOutWait: w = '{op: OP_NOP,      cond: CD_OUT_BUSY, target: StOutWait};
      StEmit:    w = '{op: OP_EMIT,     cond: CD_ALWAYS,   target: StIdle};
      default:   w = '{op: OP_NOP,      cond: CD_ALWAYS,   target: StIdle};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base ** exponent mod modulus by left-to-right square-and-multiply.
// ----------------------------------------------------------------------------
// The work is done by the single shared modular multiplier, which handles one
// multiplier bit per cycle: one product reduces the base, then each of the 31
// exponent bits takes a square and, for a one bit, a multiply by the base.
// A small microcode program steps the datapath. A new word is taken as soon
// as the previous result sits in the output register; a new result waits
// while the previous one has not been taken. A modulus of zero gives zero;
// the modulus resets to 998244353.
module modular_exponentiation (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [modexp_pkg::FieldW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [modexp_pkg::FieldW-1:0]     base_i,
  input  logic [modexp_pkg::FieldW-1:0]     exponent_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [modexp_pkg::FieldW-1:0]     power_result_o
);

  localparam int unsigned W = modexp_pkg::FieldW;

  logic [modexp_pkg::UpcW-1:0]    upc_q, upc_d;
  modexp_pkg::ucode_t             uw;
  logic                           taken;

  logic [W-1:0]                   mod_q;
  logic [W-1:0]                   acc_q, acc_d;
  logic [W-1:0]                   base_q, base_d;
  logic [modexp_pkg::ExpBits-1:0] exp_q, exp_d;
  logic [modexp_pkg::ExpCntW-1:0] bit_q, bit_d;
  logic [W-1:0]                   x_q, x_d;
  logic [W-1:0]                   y_q, y_d;
  logic [W-1:0]                   r_q, r_d;
  logic [modexp_pkg::MulCntW-1:0] cnt_q, cnt_d;
  logic                           out_valid_q, out_valid_d;
  logic [W-1:0]                   out_data_q, out_data_d;

  logic [W-1:0]                   one_val;
  logic [W+1:0]                   r2, m1, m2, sub1, sub2;
  logic [W-1:0]                   r_next;

  assign uw = modexp_pkg::ucode_rom(upc_q);

  // 1 mod m
  assign one_val = {{(W-1){1'b0}}, (mod_q > W'(1))};

  // interleaved multiply step: r = 2r + bit*x, reduced by up to two moduli
  assign r2   = {1'b0, r_q, 1'b0} + (y_q[W-1] ? {2'b00, x_q} : '0);
  assign m1   = {2'b00, mod_q};
  assign m2   = {1'b0, mod_q, 1'b0};
  assign sub1 = r2 - m1;
  assign sub2 = r2 - m2;
  always_comb begin
    if (r2 >= m2) begin
      r_next = sub2[W-1:0];
    end else if (r2 >= m1) begin
      r_next = sub1[W-1:0];
    end else begin
      r_next = r2[W-1:0];
    end
  end

  // sequencer
  always_comb begin
    taken = 1'b0;
    unique case (uw.cond)
      modexp_pkg::CD_NEVER:    taken = 1'b0;
      modexp_pkg::CD_ALWAYS:   taken = 1'b1;
      modexp_pkg::CD_NO_INPUT: taken = !in_valid_i;
      modexp_pkg::CD_MUL_BUSY: taken = (cnt_q != '0);
      modexp_pkg::CD_BIT_ZERO: taken = !exp_q[modexp_pkg::ExpBits-1];
      modexp_pkg::CD_BIT_MORE: taken = (bit_q != '0);
      modexp_pkg::CD_OUT_BUSY: taken = out_valid_q && !out_ready_i;
      default:                 taken = 1'b1;
    endcase
    upc_d = taken ? uw.target : upc_q + 1'b1;
  end

  // datapath
  always_comb begin
    acc_d      = acc_q;
    base_d     = base_q;
    exp_d      = exp_q;
    bit_d      = bit_q;
    x_d        = x_q;
    y_d        = y_q;
    r_d        = r_q;
    cnt_d      = cnt_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (uw.op)
      modexp_pkg::OP_NOP: begin
      end
      modexp_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          base_d = base_i;
          exp_d  = exponent_i[modexp_pkg::ExpBits-1:0];
          acc_d  = one_val;
        end
      end
      modexp_pkg::OP_LD_BASE: begin
        // base mod m as the product 1 * base
        x_d   = one_val;
        y_d   = base_q;
        r_d   = '0;
        cnt_d = modexp_pkg::MulCntW'(W - 1);
      end
      modexp_pkg::OP_MUL: begin
        r_d   = r_next;
        y_d   = {y_q[W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end
      modexp_pkg::OP_WB_BASE: begin
        base_d = r_q;
        bit_d  = modexp_pkg::ExpCntW'(modexp_pkg::ExpBits - 1);
      end
      modexp_pkg::OP_LD_SQ: begin
        x_d   = acc_q;
        y_d   = acc_q;
        r_d   = '0;
        cnt_d = modexp_pkg::MulCntW'(W - 1);
      end
      modexp_pkg::OP_WB_ACC: begin
        acc_d = r_q;
      end
      modexp_pkg::OP_LD_MB: begin
        x_d   = acc_q;
        y_d   = base_q;
        r_d   = '0;
        cnt_d = modexp_pkg::MulCntW'(W - 1);
      end
      modexp_pkg::OP_NEXT_BIT: begin
        exp_d = {exp_q[modexp_pkg::ExpBits-2:0], 1'b0};
        bit_d = bit_q - 1'b1;
      end
      modexp_pkg::OP_EMIT: begin
        out_data_d  = (mod_q == '0) ? '0 : acc_q;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= modexp_pkg::StIdle;
      mod_q       <= modexp_pkg::ModulusReset;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    base_q     <= base_d;
    exp_q      <= exp_d;
    bit_q      <= bit_d;
    x_q        <= x_d;
    y_q        <= y_d;
    r_q        <= r_d;
    cnt_q      <= cnt_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o     = (upc_q == modexp_pkg::StIdle);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_data_q;

endmodule

@@ hw/rtl/modexp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_port_checks
// Port-level checks for the modular exponentiation block.
// ----------------------------------------------------------------------------
module modexp_port_checks (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [modexp_pkg::FieldW-1:0] cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [modexp_pkg::FieldW-1:0] power_result_o
);

  // shadow of the modulus register
  logic [modexp_pkg::FieldW-1:0] mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= modexp_pkg::ModulusReset;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(power_result_o))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mod_q != '0) |-> power_result_o < mod_q)
    else $error("result not reduced below the modulus");

  a_zero_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mod_q == '0) |-> power_result_o == '0)
    else $error("nonzero result for a zero modulus");

endmodule

bind modular_exponentiation modexp_port_checks u_modexp_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_we_i       (cfg_we_i),
  .cfg_wdata_i    (cfg_wdata_i),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .power_result_o (power_result_o)
);
